// ===== hdl/uuid_text_parser_defines.svh =====
// ---------------------------------------------------------------------------
// uuid_text_parser_defines.svh
// Assertion macros used by the checker file of the identifier parser.
// ---------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_DEFINES_SVH
`define UUID_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UUIDP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uuid_text_parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UUIDP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uuid_text_parser check failed");

`endif

// ===== hdl/uuidp_pkg.sv =====
// ---------------------------------------------------------------------------
// uuidp_pkg
// Types, constants and helpers shared by the identifier text parser.
// ---------------------------------------------------------------------------
package uuidp_pkg;

    localparam int POS_W       = 6;
    localparam int CHAR_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int HALF_W      = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int M_FIELDS_W  = 1 + 2 * HALF_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    localparam logic [POS_W-1:0] LAST_POS = 6'd35;  // index of the 36th character
    localparam logic [POS_W-1:0] TEXT_LEN = 6'd36;
    localparam logic [POS_W-1:0] POS_MAX  = 6'd63;

    localparam logic [POS_W-1:0] HYPHEN_POS_A = 6'd8;
    localparam logic [POS_W-1:0] HYPHEN_POS_B = 6'd13;
    localparam logic [POS_W-1:0] HYPHEN_POS_C = 6'd18;
    localparam logic [POS_W-1:0] HYPHEN_POS_D = 6'd23;

    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_F      = 8'h66;
    localparam logic [NIBBLE_W-1:0] NIBBLE_TEN = 4'd10;

    // One classified character as it travels from the front end to the back end.
    typedef struct packed {
        logic                last;
        logic                bad;
        logic                shift_en;
        logic [NIBBLE_W-1:0] nibble;
        logic                len_ok;
    } token_t;

    typedef struct packed {
        logic                valid;
        logic [NIBBLE_W-1:0] value;
    } hex_t;

    // Lower-case hex digit decode.
    function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_t         h;
        logic [CHAR_W-1:0] d;
        h = '0;
        d = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d       = c - CHAR_0;
            h.valid = 1'b1;
            h.value = d[NIBBLE_W-1:0];
        end else if (c >= CHAR_A && c <= CHAR_F) begin
            d       = c - CHAR_A;
            h.valid = 1'b1;
            h.value = d[NIBBLE_W-1:0] + NIBBLE_TEN;
        end
        return h;
    endfunction

endpackage

// ===== hdl/uuid_text_parser.sv =====
// ---------------------------------------------------------------------------
// uuid_text_parser
// Parser for the canonical lower-case text form of a 128-bit identifier.
// ---------------------------------------------------------------------------
// Throughput: one character per cycle while the queue is not full; the queue
// and the output register let a new beat in while a result waits. A last
// character passes through the queue into the output register behind m_tvalid,
// waiting in the queue while an unread result holds the output register.
// Reset: aresetn (synchronous, active low) clears the position, the latched
// fault, the accumulator, the queue and the output valid.
module uuid_text_parser #(
    parameter int QUEUE_DEPTH = uuidp_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [uuidp_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] character
    input  logic                             s_tlast,   // last_char
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] id_ok, [64:1] id_upper, [128:65] id_lower, [135:129] zero
    output logic [uuidp_pkg::M_TDATA_W-1:0]  m_tdata
);
    logic                           push, pop, queue_full, queue_empty;
    uuidp_pkg::token_t              push_tok, head_tok;
    logic                           id_ok;
    logic [uuidp_pkg::HALF_W-1:0]   id_upper, id_lower;

    uuidp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_tok   (push_tok)
    );

    uuidp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tok (push_tok),
        .full     (queue_full),
        .pop      (pop),
        .head_tok (head_tok),
        .empty    (queue_empty)
    );

    uuidp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .head_tok    (head_tok),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .id_ok       (id_ok),
        .id_upper    (id_upper),
        .id_lower    (id_lower)
    );

    assign m_tdata = {{uuidp_pkg::M_PAD_W{1'b0}}, id_lower, id_upper, id_ok};

endmodule

// ===== hdl/uuidp_queue.sv =====
// ---------------------------------------------------------------------------
// uuidp_queue
// Short first-in first-out queue of classified characters.
// ---------------------------------------------------------------------------
module uuidp_queue #(
    parameter int DEPTH = uuidp_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  uuidp_pkg::token_t push_tok,
    output logic              full,
    input  logic              pop,
    output uuidp_pkg::token_t head_tok,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    uuidp_pkg::token_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_tok = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ===== hdl/uuidp_front.sv =====
// ---------------------------------------------------------------------------
// uuidp_front
// Accepts characters, tracks the position in the string and classifies each
// character against the canonical layout.
// ---------------------------------------------------------------------------
module uuidp_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uuidp_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] character
    input  logic                           s_tlast,   // last_char
    input  logic                           queue_full,
    output logic                           push,
    output uuidp_pkg::token_t              push_tok
);
    logic [uuidp_pkg::POS_W-1:0] pos_reg, pos_next;
    uuidp_pkg::hex_t             hex;
    logic                        hyphen_slot;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        hex         = uuidp_pkg::hex_decode(s_tdata);
        hyphen_slot = pos_reg inside {uuidp_pkg::HYPHEN_POS_A, uuidp_pkg::HYPHEN_POS_B,
                                      uuidp_pkg::HYPHEN_POS_C, uuidp_pkg::HYPHEN_POS_D};
        push_tok        = '0;
        push_tok.last   = s_tlast;
        push_tok.len_ok = (pos_reg == uuidp_pkg::LAST_POS);
        push_tok.nibble = hex.value;
        if (pos_reg >= uuidp_pkg::TEXT_LEN) begin
            push_tok.bad = 1'b1;
        end else if (hyphen_slot) begin
            push_tok.bad = (s_tdata != uuidp_pkg::CHAR_HYPHEN);
        end else begin
            push_tok.bad      = !hex.valid;
            push_tok.shift_en = hex.valid;
        end

        pos_next = pos_reg;
        if (push) begin
            if (s_tlast) begin
                pos_next = '0;
            end else if (pos_reg != uuidp_pkg::POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== hdl/uuidp_back.sv =====
// ---------------------------------------------------------------------------
// uuidp_back
// Shifts digit nibbles into the 128-bit value, latches faults and registers
// one result per string.
// ---------------------------------------------------------------------------
module uuidp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           queue_empty,
    input  uuidp_pkg::token_t              head_tok,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           id_ok,
    output logic [uuidp_pkg::HALF_W-1:0]   id_upper,
    output logic [uuidp_pkg::HALF_W-1:0]   id_lower
);
    localparam int ACC_W = 2 * uuidp_pkg::HALF_W;

    logic [ACC_W-1:0]            acc_reg, acc_next, acc_shift;
    logic                        fault_reg, fault_next, fault_upd;
    logic                        nz_reg, nz_next, nz_upd;
    logic                        valid_reg, valid_next;
    logic                        ok_reg, ok_next;
    logic [ACC_W-1:0]            value_reg, value_next;

    // A last beat needs the output register free; other beats drain freely.
    assign pop = !queue_empty && (!head_tok.last || !valid_reg || m_tready);

    always_comb begin
        acc_shift = {acc_reg[ACC_W-uuidp_pkg::NIBBLE_W-1:0], head_tok.nibble};
        fault_upd = fault_reg || head_tok.bad;
        nz_upd    = nz_reg || (head_tok.shift_en && (head_tok.nibble != '0));
        acc_next   = acc_reg;
        fault_next = fault_reg;
        nz_next    = nz_reg;
        valid_next = valid_reg && !m_tready;
        ok_next    = ok_reg;
        value_next = value_reg;
        if (pop) begin
            if (head_tok.shift_en) begin
                acc_next = acc_shift;
            end
            fault_next = fault_upd;
            nz_next    = nz_upd;
            if (head_tok.last) begin
                valid_next = 1'b1;
                ok_next    = !fault_upd && head_tok.len_ok && nz_upd;
                value_next = ok_next ? acc_next : '0;
                acc_next   = '0;
                fault_next = 1'b0;
                nz_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            fault_reg <= 1'b0;
            nz_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            fault_reg <= fault_next;
            nz_reg    <= nz_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg    <= ok_next;
        value_reg <= value_next;
    end

    assign m_tvalid = valid_reg;
    assign id_ok    = ok_reg;
    assign id_upper = value_reg[ACC_W-1:uuidp_pkg::HALF_W];
    assign id_lower = value_reg[uuidp_pkg::HALF_W-1:0];

endmodule

// ===== hdl/uuidp_checker.sv =====
// ---------------------------------------------------------------------------
// uuidp_checker
// Port-level checks on the result channel of the identifier parser.
// ---------------------------------------------------------------------------
`include "uuid_text_parser_defines.svh"

module uuidp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [uuidp_pkg::M_TDATA_W-1:0]  m_tdata
);
    // A stalled result beat keeps its valid and its payload.
    `UUIDP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A rejected identifier carries an all-zero value.
    `UUIDP_ASSERT_NOW(a_bad_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[128:1] == '0)

    // An accepted identifier is never the all-zero value.
    `UUIDP_ASSERT_NOW(a_ok_nonzero, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[128:1] != '0)

    // The padding above the fields stays zero.
    `UUIDP_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[135:129] == '0)

endmodule

bind uuid_text_parser uuidp_checker u_uuidp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/uuid_text_parser_tb.sv =====
// ---------------------------------------------------------------------------
// uuid_text_parser_tb
// Self-checking testbench for the identifier text parser. Character beats are
// sent on the slave stream and each one is fed into a behavioral parser kept
// in the testbench. Each expected result is queued when its last character
// is accepted, and every beat on the master stream is compared with the
// oldest entry. Directed strings cover the value extremes, each kind of bad
// character and the length corner cases. Random strings, mostly well formed
// and partly damaged, plus raw byte noise follow under varied sender gaps and
// receiver stalls.
// ---------------------------------------------------------------------------
module uuid_text_parser_tb;
    import uuidp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam string SAMPLE_ID = "01234567-89ab-cdef-0123-456789abcdef";

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SLOW,
        RX_PERIODIC
    } rx_pattern_e;

    typedef enum int {
        FLAW_NONE,
        FLAW_UPPER,
        FLAW_SWAP_HYPHEN,
        FLAW_RANDOM_BYTE,
        FLAW_DROP,
        FLAW_EXTRA,
        FLAW_TRUNCATE,
        FLAW_LONG
    } flaw_e;

    typedef struct packed {
        logic              ok;
        logic [HALF_W-1:0] upper;
        logic [HALF_W-1:0] lower;
    } id_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    uuid_text_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Parser state as the testbench tracks it.
    logic [POS_W-1:0]  prs_pos     = '0;
    logic              prs_fault   = 1'b0;
    logic [HALF_W-1:0] prs_hi      = '0;
    logic [HALF_W-1:0] prs_lo      = '0;
    logic              prs_nonzero = 1'b0;

    id_result_t        expected_ids[$];
    id_result_t        rx_want;
    logic [CHAR_W-1:0] text_q[$];
    int                errors = 0;

    // Sender and receiver pacing.
    int          tx_max_gap    = 0;
    int          tx_max_burst  = 0;
    int          tx_burst_left = 0;
    logic        tx_holding    = 1'b0;
    rx_pattern_e rx_pattern    = RX_ALWAYS;
    int          rx_count      = 0;
    int          idle_cycles   = 0;

    function automatic logic is_hyphen_slot(input logic [POS_W-1:0] p);
        return p == HYPHEN_POS_A || p == HYPHEN_POS_B || p == HYPHEN_POS_C ||
               p == HYPHEN_POS_D;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input int v);
        return (v < 10) ? CHAR_0 + CHAR_W'(v) : CHAR_A + CHAR_W'(v - 10);
    endfunction

    // Adds one character to the end of the buffered text.
    task automatic append_char(input logic [CHAR_W-1:0] c);
        text_q = {text_q, c};
    endtask

    // Advances the tracked parser by one accepted character and queues the
    // identifier that a last character produces.
    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
        logic                is_digit;
        logic                is_letter;
        logic [NIBBLE_W-1:0] nib;
        id_result_t          res;
        is_digit  = c >= CHAR_0 && c <= CHAR_9;
        is_letter = c >= CHAR_A && c <= CHAR_F;
        // Digits and the letters a-f both carry their value in the low nibble,
        // the letters offset by nine.
        nib = c[NIBBLE_W-1:0] + (is_letter ? 4'd9 : 4'd0);
        if (prs_pos >= TEXT_LEN) begin
            prs_fault = 1'b1;
        end else if (is_hyphen_slot(prs_pos)) begin
            if (c != CHAR_HYPHEN) prs_fault = 1'b1;
        end else if (!(is_digit || is_letter)) begin
            prs_fault = 1'b1;
        end else begin
            {prs_hi, prs_lo} = {prs_hi[HALF_W-NIBBLE_W-1:0], prs_lo, nib};
            if (nib != '0) prs_nonzero = 1'b1;
        end
        if (prs_pos != POS_MAX) prs_pos = prs_pos + 1'b1;
        if (last) begin
            res.ok    = !prs_fault && prs_pos == TEXT_LEN && prs_nonzero;
            res.upper = res.ok ? prs_hi : '0;
            res.lower = res.ok ? prs_lo : '0;
            expected_ids = {expected_ids, res};
            prs_pos     = '0;
            prs_fault   = 1'b0;
            prs_hi      = '0;
            prs_lo      = '0;
            prs_nonzero = 1'b0;
        end
    endtask

    // Sends one character beat; called only right after a rising edge.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        s_tdata    <= c;
        s_tlast    <= last;
        s_tvalid   <= 1'b1;
        tx_holding = 1'b1;
        do @(posedge aclk); while (!s_tready);
        parse_char(c, last);
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end else begin
            gap           = $urandom_range(0, tx_max_gap);
            tx_burst_left = $urandom_range(0, tx_max_burst);
            if (gap > 0) begin
                s_tvalid   <= 1'b0;
                tx_holding = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++) append_char(s[i]);
    endtask

    // Sends the buffered text as one string, last flag on its final beat.
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic set_pacing(input int max_gap, input int max_burst, input rx_pattern_e rx);
        tx_max_gap    = max_gap;
        tx_max_burst  = max_burst;
        tx_burst_left = 0;
        rx_pattern    = rx;
    endtask

    // Receiver stalls.
    always @(posedge aclk) begin
        rx_count <= rx_count + 1;
        case (rx_pattern)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= $urandom_range(0, 3) != 0;
            RX_SLOW:     m_tready <= $urandom_range(0, 3) == 0;
            default:     m_tready <= (rx_count % 13) > 8;
        endcase
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ids.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                rx_want = expected_ids.pop_front();
                if (m_tdata[0] !== rx_want.ok) begin
                    errors++;
                    $display("%0t: id_ok mismatch, expected %b, actual %b",
                             $time, rx_want.ok, m_tdata[0]);
                end
                if (m_tdata[HALF_W:1] !== rx_want.upper) begin
                    errors++;
                    $display("%0t: id_upper mismatch, expected %h, actual %h",
                             $time, rx_want.upper, m_tdata[HALF_W:1]);
                end
                if (m_tdata[2*HALF_W:HALF_W+1] !== rx_want.lower) begin
                    errors++;
                    $display("%0t: id_lower mismatch, expected %h, actual %h",
                             $time, rx_want.lower, m_tdata[2*HALF_W:HALF_W+1]);
                end
                if (m_tdata[M_TDATA_W-1:M_FIELDS_W] !== '0) begin
                    errors++;
                    $display("%0t: padding mismatch, expected 0, actual %h",
                             $time, m_tdata[M_TDATA_W-1:M_FIELDS_W]);
                end
            end
        end
    end

    // Watchdog on beats moving on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed();
        logic [CHAR_W-1:0] odd_chars[7];
        odd_chars = '{8'h2F, 8'h3A, 8'h60, 8'h67, 8'h47, 8'h00, 8'hFF};
        set_pacing(0, 0, RX_ALWAYS);
        load_text("00000000-0000-0000-0000-000000000001"); send_text();
        load_text("ffffffff-ffff-ffff-ffff-ffffffffffff"); send_text();
        load_text("00000000-0000-0000-0000-000000000000"); send_text();
        load_text("10000000-0000-0000-0000-000000000000"); send_text();
        load_text(SAMPLE_ID); send_text();
        // Hyphen in a digit slot, then a digit in a hyphen slot.
        load_text("-1234567-89ab-cdef-0123-456789abcdef"); send_text();
        load_text("0123456789abc-def0-1234-56789abcdef0"); send_text();
        // Bytes just outside the digit ranges, upper case and the byte extremes.
        foreach (odd_chars[i]) begin
            load_text(SAMPLE_ID);
            text_q[3] = odd_chars[i];
            send_text();
        end
        load_text("a"); send_text();
        load_text("01234567-"); send_text();
        load_text(SAMPLE_ID); void'(text_q.pop_back()); send_text();
        load_text(SAMPLE_ID); load_text("0"); send_text();
        // Long enough for the position counter to saturate.
        load_text(SAMPLE_ID); load_text(SAMPLE_ID); send_text();
    endtask

    // Single-character strings back to back against a slow receiver fill the
    // character queue ahead of the output register.
    task automatic test_back_to_back();
        set_pacing(0, 0, RX_SLOW);
        for (int i = 0; i < 30; i++) send_char(hex_char($urandom_range(0, 15)), 1'b1);
    endtask

    task automatic build_random_id();
        int mode;
        int spot;
        mode = $urandom_range(0, 3);
        spot = $urandom_range(0, TEXT_LEN - 1);
        for (int p = 0; p < TEXT_LEN; p++) begin
            if (is_hyphen_slot(POS_W'(p))) append_char(CHAR_HYPHEN);
            else begin
                case (mode)
                    0: append_char(hex_char($urandom_range(0, 15)));
                    1: append_char(p == spot ? hex_char($urandom_range(1, 15)) : CHAR_0);
                    2: append_char(CHAR_0);
                    default: append_char(hex_char($urandom_range(0, 9)));
                endcase
            end
        end
    endtask

    task automatic damage_text(input flaw_e flaw);
        int pos;
        int extra;
        pos = $urandom_range(0, text_q.size() - 1);
        case (flaw)
            FLAW_UPPER:       text_q[pos] = CHAR_UPPER_A + CHAR_W'($urandom_range(0, 5));
            FLAW_SWAP_HYPHEN: text_q[pos] = (text_q[pos] == CHAR_HYPHEN) ?
                                  hex_char($urandom_range(0, 15)) : CHAR_HYPHEN;
            FLAW_RANDOM_BYTE: text_q[pos] = CHAR_W'($urandom_range(0, 255));
            FLAW_DROP:        text_q.delete(pos);
            FLAW_EXTRA:       text_q.insert(pos, hex_char($urandom_range(0, 15)));
            FLAW_TRUNCATE:    while (text_q.size() > pos + 1) void'(text_q.pop_back());
            FLAW_LONG: begin
                extra = $urandom_range(1, 40);
                repeat (extra) append_char(hex_char($urandom_range(0, 15)));
            end
            default: ;
        endcase
    endtask

    task automatic test_random_ids(input int count, input int max_gap, input int max_burst,
                                   input rx_pattern_e rx);
        set_pacing(max_gap, max_burst, rx);
        for (int n = 0; n < count; n++) begin
            build_random_id();
            if ($urandom_range(0, 9) < 4) damage_text(flaw_e'($urandom_range(FLAW_UPPER, FLAW_LONG)));
            send_text();
        end
    endtask

    task automatic test_noise(input int count);
        int r;
        set_pacing(2, 15, RX_SLOW);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 16);
            if ($urandom_range(0, 1) == 0)
                send_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            else
                send_char(r == 16 ? CHAR_HYPHEN : hex_char(r), $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_back_to_back();
        test_random_ids(10, 3, 8, RX_RANDOM);
        test_noise(250);
        test_random_ids(10, 20, 3, RX_PERIODIC);
        if (tx_holding) s_tvalid <= 1'b0;
        while (expected_ids.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
